>>> rtl/gcps_pkg.sv
// Shared types, constants and microcode ROM for the grid chase path search core.
`default_nettype none
package gcps_pkg;

  localparam int MAP_WORDS = 64;
  localparam int MAP_AW    = 6;
  localparam int WORD_W    = 16;
  localparam int COORD_W   = 5;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CHASE = 1'b1;

  typedef logic [2:0] dir_t;
  localparam dir_t DIR_E   = 3'd0;
  localparam dir_t DIR_W   = 3'd1;
  localparam dir_t DIR_S   = 3'd2;
  localparam dir_t DIR_N   = 3'd3;
  localparam dir_t DIR_END = 3'd4;

  typedef enum logic [2:0] {
    A_NONE,
    A_INIT,
    A_STEP,
    A_PUSH,
    A_POP,
    A_RESTORE,
    A_FOUND,
    A_EMIT
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOGO,
    C_DIR_DONE,
    C_BLOCKED,
    C_HIT,
    C_AT_MAX,
    C_LVL0,
    C_OUT_BUSY
  } cond_t;

  typedef logic [3:0] upc_t;
  localparam upc_t UPC_IDLE    = 4'd0;
  localparam upc_t UPC_INIT    = 4'd1;
  localparam upc_t UPC_TEST    = 4'd2;
  localparam upc_t UPC_STEP    = 4'd3;
  localparam upc_t UPC_CHECK   = 4'd4;
  localparam upc_t UPC_HITCHK  = 4'd5;
  localparam upc_t UPC_DEEP    = 4'd6;
  localparam upc_t UPC_PUSH    = 4'd7;
  localparam upc_t UPC_EXH     = 4'd8;
  localparam upc_t UPC_POP     = 4'd9;
  localparam upc_t UPC_RESTORE = 4'd10;
  localparam upc_t UPC_FOUND   = 4'd11;
  localparam upc_t UPC_DONE    = 4'd12;
  localparam upc_t UPC_RET     = 4'd13;

  typedef struct packed {
    act_t  act;
    cond_t cnd;
    upc_t  tgt;
  } uword_t;

  typedef struct packed {
    logic nogo;
    logic dir_done;
    logic blocked;
    logic hit;
    logic at_max;
    logic lvl0;
    logic out_busy;
  } status_t;

  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    w = '{act: A_NONE, cnd: C_ALWAYS, tgt: UPC_IDLE};
    case (a)
      UPC_IDLE:    w = '{act: A_NONE,    cnd: C_NOGO,     tgt: UPC_IDLE};
      UPC_INIT:    w = '{act: A_INIT,    cnd: C_NEVER,    tgt: UPC_IDLE};
      UPC_TEST:    w = '{act: A_NONE,    cnd: C_DIR_DONE, tgt: UPC_EXH};
      UPC_STEP:    w = '{act: A_STEP,    cnd: C_NEVER,    tgt: UPC_IDLE};
      UPC_CHECK:   w = '{act: A_NONE,    cnd: C_BLOCKED,  tgt: UPC_TEST};
      UPC_HITCHK:  w = '{act: A_NONE,    cnd: C_HIT,      tgt: UPC_FOUND};
      UPC_DEEP:    w = '{act: A_NONE,    cnd: C_AT_MAX,   tgt: UPC_TEST};
      UPC_PUSH:    w = '{act: A_PUSH,    cnd: C_ALWAYS,   tgt: UPC_TEST};
      UPC_EXH:     w = '{act: A_NONE,    cnd: C_LVL0,     tgt: UPC_DONE};
      UPC_POP:     w = '{act: A_POP,     cnd: C_NEVER,    tgt: UPC_IDLE};
      UPC_RESTORE: w = '{act: A_RESTORE, cnd: C_ALWAYS,   tgt: UPC_TEST};
      UPC_FOUND:   w = '{act: A_FOUND,   cnd: C_NEVER,    tgt: UPC_IDLE};
      UPC_DONE:    w = '{act: A_EMIT,    cnd: C_OUT_BUSY, tgt: UPC_DONE};
      UPC_RET:     w = '{act: A_NONE,    cnd: C_ALWAYS,   tgt: UPC_IDLE};
      default:     w = '{act: A_NONE,    cnd: C_ALWAYS,   tgt: UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/gcps_wall_mem.sv
// Wall bitmap memory: one write port, one registered read port.
`default_nettype none
module gcps_wall_mem (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [gcps_pkg::MAP_AW-1:0] waddr,
  input  wire logic [gcps_pkg::WORD_W-1:0] wdata,
  input  wire logic [gcps_pkg::MAP_AW-1:0] raddr,
  output logic      [gcps_pkg::WORD_W-1:0] rdata
);
  import gcps_pkg::*;

  logic [WORD_W-1:0] mem [MAP_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/gcps_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`default_nettype none
module gcps_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gcps_pkg::status_t st,
  output gcps_pkg::uword_t       uw,
  output logic                   idle
);
  import gcps_pkg::*;

  upc_t pc_r, pc_nxt;
  logic take;

  assign uw   = ucode(pc_r);
  assign idle = (pc_r == UPC_IDLE);

  always_comb begin
    case (uw.cnd)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NOGO:     take = st.nogo;
      C_DIR_DONE: take = st.dir_done;
      C_BLOCKED:  take = st.blocked;
      C_HIT:      take = st.hit;
      C_AT_MAX:   take = st.at_max;
      C_LVL0:     take = st.lvl0;
      C_OUT_BUSY: take = st.out_busy;
      default:    take = 1'b0;
    endcase
    pc_nxt = take ? uw.tgt : pc_r + upc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UPC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/grid_chase_path_search_core.sv
// Top level: depth-limited grid path search, microcoded sequencer plus datapath.
// Write word: accepted when idle, gives no result.
// Chase word: one at a time; each neighbor is stepped to, checked for walls, reversal and the
// target, then pushed unless at the depth limit; an exhausted level pops and restores.
// Result is held in an output register until taken; in_tready is high only while idle.
// Synchronous active-low reset clears sequencer, level, direction and output valid.
`default_nettype none
module grid_chase_path_search_core #(
  parameter int MAX_DEPTH = 10,
  parameter int GRID_COLS = 32,
  parameter int GRID_ROWS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // word_index, word_data, chaser_x, chaser_y, target_x, target_y
  input  wire logic        in_tuser,  // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata, // next_x, next_y
  output logic             out_tuser  // path_found
);
  import gcps_pkg::*;

  localparam int XB  = $clog2(GRID_COLS + 1);
  localparam int YB  = $clog2(GRID_ROWS + 1);
  localparam int XW  = ((XB > COORD_W) ? XB : COORD_W) + 1;
  localparam int YW  = ((YB > COORD_W) ? YB : COORD_W) + 1;
  localparam int LW  = $clog2(MAX_DEPTH);
  localparam int WPR = (GRID_COLS + WORD_W - 1) / WORD_W;
  localparam int IW  = YW + 3;
  localparam int SW  = XW + YW + 3;

  logic [MAP_AW-1:0]  in_word_index;
  logic [WORD_W-1:0]  in_word_data;
  logic [COORD_W-1:0] in_chaser_x, in_chaser_y, in_target_x, in_target_y;

  assign in_word_index = in_tdata[5:0];
  assign in_word_data  = in_tdata[21:6];
  assign in_chaser_x   = in_tdata[26:22];
  assign in_chaser_y   = in_tdata[31:27];
  assign in_target_x   = in_tdata[36:32];
  assign in_target_y   = in_tdata[41:37];

  uword_t  uw;
  status_t st;
  logic    idle;
  logic    chase_acc;

  logic [XW-1:0]      cur_x_r, prev_x_r, nb_x_r;
  logic [YW-1:0]      cur_y_r, prev_y_r, nb_y_r;
  logic [COORD_W-1:0] first_x_r, first_y_r, res_x_r, res_y_r, tgt_x_r, tgt_y_r;
  logic [LW-1:0]      lvl_r;
  dir_t               dir_r;
  logic               found_r, off_r, out_valid_r;

  logic [XW-1:0]      sx;
  logic [YW-1:0]      sy;
  logic [IW-1:0]      sidx;
  logic               soff;
  logic [WORD_W-1:0]  wall_rd;
  logic               wall_bit;
  logic               out_busy;

  logic [SW-1:0]      stk_mem [MAX_DEPTH];
  logic [SW-1:0]      stk_rd_r;

  gcps_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .uw    (uw),
    .idle  (idle)
  );

  assign in_tready = idle;
  assign chase_acc = in_tvalid && in_tready && (in_tuser == CMD_CHASE);

  always_comb begin
    sx = cur_x_r;
    sy = cur_y_r;
    case (dir_r)
      DIR_E:   sx = cur_x_r + XW'(1);
      DIR_W:   sx = cur_x_r - XW'(1);
      DIR_S:   sy = cur_y_r + YW'(1);
      DIR_N:   sy = cur_y_r - YW'(1);
      default: sx = cur_x_r;
    endcase
    sidx = IW'(sy) * IW'(WPR) + IW'(sx >> 4);
    soff = (sx >= XW'(GRID_COLS)) || (sy >= YW'(GRID_ROWS)) || (sidx >= IW'(MAP_WORDS));
  end

  gcps_wall_mem u_wall (
    .clk   (clk),
    .we    (in_tvalid && in_tready && (in_tuser == CMD_WRITE)),
    .waddr (in_word_index),
    .wdata (in_word_data),
    .raddr (sidx[MAP_AW-1:0]),
    .rdata (wall_rd)
  );

  assign wall_bit = wall_rd[4'd15 - nb_x_r[3:0]];
  assign out_busy = out_valid_r && !out_tready;

  always_comb begin
    st.nogo     = !(in_tvalid && (in_tuser == CMD_CHASE));
    st.dir_done = (dir_r == DIR_END);
    st.blocked  = off_r || wall_bit ||
                  ((lvl_r != '0) && (nb_x_r == prev_x_r) && (nb_y_r == prev_y_r));
    st.hit      = (nb_x_r == XW'(tgt_x_r)) && (nb_y_r == YW'(tgt_y_r));
    st.at_max   = (lvl_r == LW'(MAX_DEPTH - 1));
    st.lvl0     = (lvl_r == '0);
    st.out_busy = out_busy;
  end

  // path stack: entry k holds the cell before level k and the direction count of level k
  always_ff @(posedge clk) begin
    if (uw.act == A_PUSH) begin
      stk_mem[lvl_r] <= {prev_x_r, prev_y_r, dir_r};
    end
    stk_rd_r <= stk_mem[lvl_r - LW'(1)];
  end

  // chase fields are captured on the accepting edge
  always_ff @(posedge clk) begin
    if (chase_acc) begin
      cur_x_r <= XW'(in_chaser_x);
      cur_y_r <= YW'(in_chaser_y);
      tgt_x_r <= in_target_x;
      tgt_y_r <= in_target_y;
      res_x_r <= in_chaser_x;
      res_y_r <= in_chaser_y;
    end else begin
      case (uw.act)
        A_STEP: begin
          nb_x_r <= sx;
          nb_y_r <= sy;
          off_r  <= soff;
        end
        A_PUSH: begin
          prev_x_r <= cur_x_r;
          prev_y_r <= cur_y_r;
          cur_x_r  <= nb_x_r;
          cur_y_r  <= nb_y_r;
          if (lvl_r == '0) begin
            first_x_r <= nb_x_r[COORD_W-1:0];
            first_y_r <= nb_y_r[COORD_W-1:0];
          end
        end
        A_POP: begin
          cur_x_r <= prev_x_r;
          cur_y_r <= prev_y_r;
        end
        A_RESTORE: begin
          prev_x_r <= stk_rd_r[SW-1 -: XW];
          prev_y_r <= stk_rd_r[YW+2 -: YW];
        end
        A_FOUND: begin
          res_x_r <= (lvl_r == '0) ? nb_x_r[COORD_W-1:0] : first_x_r;
          res_y_r <= (lvl_r == '0) ? nb_y_r[COORD_W-1:0] : first_y_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r       <= '0;
      dir_r       <= DIR_E;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_tuser   <= 1'b0;
    end else begin
      case (uw.act)
        A_INIT: begin
          lvl_r   <= '0;
          dir_r   <= DIR_E;
          found_r <= 1'b0;
        end
        A_STEP:    dir_r <= dir_r + dir_t'(1);
        A_PUSH: begin
          lvl_r <= lvl_r + LW'(1);
          dir_r <= DIR_E;
        end
        A_POP:     lvl_r <= lvl_r - LW'(1);
        A_RESTORE: dir_r <= stk_rd_r[2:0];
        A_FOUND:   found_r <= 1'b1;
        default: begin
        end
      endcase
      if (uw.act == A_EMIT && !out_busy) begin
        out_valid_r <= 1'b1;
        out_tuser   <= found_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (uw.act == A_EMIT && !out_busy) begin
      out_tdata <= {6'b0, res_y_r, res_x_r};
    end
  end

  assign out_tvalid = out_valid_r;

  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= LW'(MAX_DEPTH - 1))
    else $error("search level beyond depth limit");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    dir_r <= DIR_END)
    else $error("direction counter out of range");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid)) |-> $past(uw.act == A_EMIT))
    else $error("result raised outside of emit step");

  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.act == A_EMIT && out_busy) |=> (uw.act == A_EMIT))
    else $error("sequencer left done step while output busy");

endmodule
`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the grid chase path search core: base map, directed table, then random words.
`timescale 1ns / 1ps
module tb_top;
  import gcps_pkg::*;

  localparam int MAX_DEPTH     = 10;
  localparam int GRID_COLS     = 32;
  localparam int GRID_ROWS     = 32;
  localparam int WORDS_PER_ROW = (GRID_COLS + WORD_W - 1) / WORD_W;
  localparam int N_DIRECTED    = 20;
  localparam int N_RANDOM      = 20;
  localparam int WORK_CAP      = 1500;
  localparam int WORK_CAP_BIG  = 12000;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 2000000;
  localparam int DRAIN_CYCLES  = 100;

  typedef struct packed {
    logic [4:0] nx;
    logic [4:0] ny;
    logic       hit;
  } move_t;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  idx;
    logic [15:0] data;
    logic [4:0]  cx, cy, tx, ty;
    logic        typed;
    logic [4:0]  ex, ey;
    logic        ef;
  } drow_t;

  // cmd, idx, data, chaser x/y, target x/y, typed, expected x/y/found
  localparam drow_t DTAB [N_DIRECTED] = '{
    '{CMD_CHASE, 6'h3F, 16'hFFFF,  5'd0,  5'd0,  5'd1,  5'd0, 1'b1,  5'd1,  5'd0, 1'b1},
    '{CMD_CHASE, 6'h00, 16'h0000,  5'd0,  5'd0,  5'd0,  5'd0, 1'b0,  5'd0,  5'd0, 1'b0},
    '{CMD_CHASE, 6'h15, 16'hA5A5,  5'd0,  5'd0,  5'd3,  5'd3, 1'b0,  5'd0,  5'd0, 1'b0},
    '{CMD_CHASE, 6'h2A, 16'h5A5A,  5'd0,  5'd0, 5'd10, 5'd10, 1'b1,  5'd0,  5'd0, 1'b0},
    '{CMD_CHASE, 6'h3F, 16'h0000, 5'd31, 5'd31, 5'd30, 5'd30, 1'b0,  5'd0,  5'd0, 1'b0},
    '{CMD_CHASE, 6'h00, 16'hFFFF, 5'd31, 5'd31, 5'd31, 5'd31, 1'b0,  5'd0,  5'd0, 1'b0},
    '{CMD_CHASE, 6'h01, 16'h8001, 5'd15, 5'd20, 5'd16, 5'd20, 1'b1, 5'd15, 5'd20, 1'b0},
    '{CMD_CHASE, 6'h02, 16'h4002,  5'd4,  5'd0,  5'd0,  5'd0, 1'b0,  5'd0,  5'd0, 1'b0},
    '{CMD_CHASE, 6'h03, 16'h2004,  5'd0,  5'd0, 5'd31, 5'd31, 1'b1,  5'd0,  5'd0, 1'b0},
    '{CMD_CHASE, 6'h04, 16'h1008,  5'd0,  5'd5, 5'd10,  5'd5, 1'b1,  5'd1,  5'd5, 1'b1},
    '{CMD_CHASE, 6'h05, 16'h0810,  5'd0,  5'd5, 5'd11,  5'd5, 1'b1,  5'd0,  5'd5, 1'b0},
    '{CMD_CHASE, 6'h06, 16'h0420, 5'd31,  5'd5, 5'd21,  5'd5, 1'b0,  5'd0,  5'd0, 1'b0},
    '{CMD_CHASE, 6'h07, 16'h0240, 5'd25,  5'd6, 5'd25,  5'd9, 1'b1, 5'd25,  5'd7, 1'b1},
    '{CMD_CHASE, 6'h08, 16'h0180, 5'd25,  5'd8, 5'd25,  5'd6, 1'b0,  5'd0,  5'd0, 1'b0},
    '{CMD_WRITE, 6'h00, 16'h07FF, 5'd31, 5'd31, 5'd31, 5'd31, 1'b0,  5'd0,  5'd0, 1'b0},
    '{CMD_CHASE, 6'h09, 16'h1234,  5'd0,  5'd0,  5'd4,  5'd0, 1'b0,  5'd0,  5'd0, 1'b0},
    '{CMD_WRITE, 6'h3F, 16'h0000, 5'd17,  5'd9,  5'd3, 5'd28, 1'b0,  5'd0,  5'd0, 1'b0},
    '{CMD_CHASE, 6'h0A, 16'hFEDC, 5'd31, 5'd31, 5'd16, 5'd31, 1'b0,  5'd0,  5'd0, 1'b0},
    '{CMD_WRITE, 6'h00, 16'hFFFF,  5'd0,  5'd0,  5'd0,  5'd0, 1'b0,  5'd0,  5'd0, 1'b0},
    '{CMD_CHASE, 6'h0B, 16'h0F0F,  5'd0,  5'd1,  5'd0,  5'd0, 1'b1,  5'd0,  5'd1, 1'b0}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;  // word_index, word_data, chaser_x, chaser_y, target_x, target_y
  logic        in_tuser   = 1'b0;  // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;  // next_x, next_y
  logic        out_tuser;  // path_found

  logic [15:0] wall_map_model [MAP_WORDS];
  move_t       pending_moves [$];
  int          n_errors  = 0;
  int          n_writes  = 0;
  int          n_chases  = 0;
  int          n_results = 0;
  int          n_found   = 0;
  int          max_work  = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  logic        rx_hold_req  = 1'b0;
  logic        rx_hold_done = 1'b0;
  int          hold_left = 0;
  logic [31:0] rx_cyc = '0;

  grid_chase_path_search_core #(
    .MAX_DEPTH(MAX_DEPTH),
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #1 clk = ~clk;

  function automatic logic wall_at(input int x, input int y);
    int idx;
    if (x < 0 || y < 0 || x >= GRID_COLS || y >= GRID_ROWS) return 1'b1;
    idx = y * WORDS_PER_ROW + x / WORD_W;
    if (idx >= MAP_WORDS) return 1'b1;
    return wall_map_model[idx][15 - (x % WORD_W)];
  endfunction

  // Depth-first search, east/west/south/north, no immediate reversal.
  // work counts neighbor tries plus backtracks, a rough cost of the search.
  function automatic move_t next_move(input logic [4:0] cx, input logic [4:0] cy,
                                      input logic [4:0] tx, input logic [4:0] ty,
                                      output int work);
    int    px [MAX_DEPTH+1];
    int    py [MAX_DEPTH+1];
    dir_t  dc [MAX_DEPTH+1];
    dir_t  d;
    int    lvl, nx, ny;
    logic  hit;
    move_t m;
    px[0] = cx;
    py[0] = cy;
    dc[0] = DIR_E;
    lvl   = 0;
    hit   = 1'b0;
    work  = 0;
    while (lvl >= 0 && !hit) begin
      work++;
      if (dc[lvl] == DIR_END) begin
        lvl--;
      end else begin
        d       = dc[lvl];
        dc[lvl] = dir_t'(dc[lvl] + 3'd1);
        nx      = px[lvl];
        ny      = py[lvl];
        case (d)
          DIR_E:   nx = nx + 1;
          DIR_W:   nx = nx - 1;
          DIR_S:   ny = ny + 1;
          default: ny = ny - 1;
        endcase
        if (!wall_at(nx, ny) && !(lvl > 0 && nx == px[lvl-1] && ny == py[lvl-1])) begin
          px[lvl+1] = nx;
          py[lvl+1] = ny;
          if (nx == int'(tx) && ny == int'(ty)) begin
            hit = 1'b1;
          end else if (lvl + 1 < MAX_DEPTH) begin
            lvl++;
            dc[lvl] = DIR_E;
          end
        end
      end
    end
    if (hit) m = '{nx: px[1][4:0], ny: py[1][4:0], hit: 1'b1};
    else m = '{nx: cx, ny: cy, hit: 1'b0};
    return m;
  endfunction

  function automatic logic [47:0] pack_word(input logic [5:0] idx, input logic [15:0] data,
                                            input logic [4:0] cx, input logic [4:0] cy,
                                            input logic [4:0] tx, input logic [4:0] ty);
    return {6'b0, ty, tx, cy, cx, data, idx};
  endfunction

  // Walled grid with a 4x4 room at the top left, an open row 5, a shaft down
  // column 25 and a 2x2 pocket in the bottom right corner.
  function automatic logic [15:0] base_word(input int i);
    if (i == 0 || i == 2 || i == 4 || i == 6) return 16'h0FFF;
    if (i == 10 || i == 11) return 16'h0000;
    if (i >= 13 && i <= 31 && i % 2 == 1) return 16'hFFBF;
    if (i == 61 || i == 63) return 16'hFFFC;
    return 16'hFFFF;
  endfunction

  function automatic logic [15:0] dense_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      3, 4:    return 16'($urandom | $urandom);
      default: return 16'($urandom | ($urandom & $urandom));
    endcase
  endfunction

  function automatic logic [4:0] near(input logic [4:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 31) v = 31;
    return v[4:0];
  endfunction

  task automatic send_word(input logic cmd, input logic [47:0] data,
                           input logic typed, input move_t typed_exp);
    int    gap;
    int    work;
    move_t m;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_WRITE) begin
      wall_map_model[data[5:0]] = data[21:6];
      n_writes++;
    end else begin
      m = next_move(data[26:22], data[31:27], data[36:32], data[41:37], work);
      if (typed) m = typed_exp;
      pending_moves.push_back(m);
      n_chases++;
      if (work > max_work) max_work = work;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 9);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // receiver: rotating ready patterns, plus one long hold-off on request
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (rx_hold_req && !rx_hold_done) begin
      out_tready   <= 1'b0;
      hold_left    <= LONG_HOLD;
      rx_hold_done <= 1'b1;
    end else begin
      case (rx_cyc[7:6])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_tready <= (rx_cyc % 5 < 2);
        default: out_tready <= $urandom_range(0, 1);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    move_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (out_tuser) n_found++;
      if (pending_moves.size() == 0) begin
        $error("unexpected result word: next_x=%0d next_y=%0d path_found=%0b",
               out_tdata[4:0], out_tdata[9:5], out_tuser);
        n_errors++;
      end else begin
        want = pending_moves.pop_front();
        if (out_tdata[4:0] !== want.nx) begin
          $error("next_x: expected %0d, got %0d", want.nx, out_tdata[4:0]);
          n_errors++;
        end
        if (out_tdata[9:5] !== want.ny) begin
          $error("next_y: expected %0d, got %0d", want.ny, out_tdata[9:5]);
          n_errors++;
        end
        if (out_tuser !== want.hit) begin
          $error("path_found: expected %0b, got %0b", want.hit, out_tuser);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int         i, k, a, work, cap;
    logic       is_chase;
    logic [4:0] cx, cy, tx, ty;
    move_t      dummy;
    drow_t      row;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < MAP_WORDS; i++)
      send_word(CMD_WRITE, pack_word(i[5:0], base_word(i), 5'd31, 5'd0, 5'd31, 5'd0), 1'b0, '0);
    for (i = 0; i < N_DIRECTED; i++) begin
      row = DTAB[i];
      send_word(row.cmd, pack_word(row.idx, row.data, row.cx, row.cy, row.tx, row.ty),
                row.typed, move_t'{row.ex, row.ey, row.ef});
    end

    // mixed words on the mostly walled grid
    for (k = 0; k < N_RANDOM; k++) begin
      if (k == 3) rx_hold_req <= 1'b1;
      if (k == 12) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_moves.size() != 0);
      end
      is_chase = 1'b0;
      if ($urandom_range(0, 99) >= 15) begin
        cap = (k % 10 == 9) ? WORK_CAP_BIG : WORK_CAP;
        for (a = 0; a < 40 && !is_chase; a++) begin
          cx = $urandom_range(0, 31);
          cy = $urandom_range(0, 31);
          if ($urandom_range(0, 4) != 0)
            for (i = 0; i < 40 && wall_at(cx, cy); i++) begin
              cx = $urandom_range(0, 31);
              cy = $urandom_range(0, 31);
            end
          if ($urandom_range(0, 9) < 6) begin
            tx = near(cx);
            ty = near(cy);
          end else begin
            tx = $urandom_range(0, 31);
            ty = $urandom_range(0, 31);
          end
          dummy = next_move(cx, cy, tx, ty, work);
          if (work <= cap) is_chase = 1'b1;
        end
      end
      if (is_chase)
        send_word(CMD_CHASE, pack_word(6'($urandom), 16'($urandom), cx, cy, tx, ty), 1'b0, '0);
      else
        send_word(CMD_WRITE, pack_word(6'($urandom), dense_word(), 5'($urandom),
                  5'($urandom), 5'($urandom), 5'($urandom)), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results from %0d chase and %0d map-write words; %0d hit.",
             n_results, n_chases, n_writes, n_found);
    $display("Largest search cost %0d tries, with a long output hold-off and a full drain mid-run.",
             max_work);
    if (n_errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
